// ===== rtl/core/cjfb_pkg.sv =====
package cjfb_pkg;

  localparam int unsigned CJFB_QUEUE_DEPTH = 4;

  localparam logic [4:0]  CRC5_SEED  = 5'h1F;
  localparam logic [4:0]  CRC5_POLY  = 5'h05;
  localparam logic [15:0] CRC16_SEED = 16'hFFFF;
  localparam logic [15:0] CRC16_POLY = 16'h1021;

  localparam logic [2:0] REG_PREAMBLE_FIRST  = 3'd0;
  localparam logic [2:0] REG_PREAMBLE_SECOND = 3'd1;
  localparam logic [2:0] REG_COMMAND_TYPE    = 3'd2;
  localparam logic [2:0] REG_JOB_TYPE        = 3'd3;
  localparam logic [2:0] REG_BROADCAST_GROUP = 3'd4;

  typedef struct packed {
    logic [7:0] preamble_first;
    logic [7:0] preamble_second;
    logic [7:0] command_type_bits;
    logic [7:0] job_type_bits;
    logic [7:0] broadcast_group_bits;
  } cfg_t;

  // one classified input beat waiting for the byte sequencer
  typedef struct packed {
    logic       kind;
    logic       start;
    logic       finish;
    logic       has_byte;
    logic [7:0] data;
    logic [7:0] hdr;
    logic [7:0] len;
    logic [7:0] addr;
  } job_entry_t;

  typedef enum logic [3:0] {
    SL_PRE1,
    SL_PRE2,
    SL_HDR,
    SL_LEN,
    SL_ADDR,
    SL_DATA,
    SL_CRC_HI,
    SL_CRC_LO,
    SL_CRC5,
    SL_DONE
  } slot_e;

  function automatic logic [4:0] crc5_byte(input logic [4:0] crc, input logic [7:0] b);
    logic [4:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[4] ^ b[i];
      c  = {c[3:0], 1'b0};
      if (fb) c = c ^ CRC5_POLY;
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC16_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/cjfb_front.sv =====
module cjfb_front
  import cjfb_pkg::*;
(
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic       frame_kind_i,
  input  logic       start_req_i,
  input  logic       finish_i,
  input  logic       has_byte_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] command_code_i,
  input  logic [7:0] group_code_i,
  input  logic [7:0] register_address_i,
  input  logic [7:0] payload_length_i,
  input  cfg_t       cfg_i,
  input  logic       full_i,
  output logic       push_o,
  output job_entry_t entry_o
);

  logic useful;

  // a beat with no start, no byte and no finish yields nothing, drop it here
  assign useful    = start_req_i | finish_i | has_byte_i;
  assign s_ready_o = ~full_i;
  assign push_o    = s_valid_i & ~full_i & useful;

  always_comb begin
    entry_o.kind     = frame_kind_i;
    entry_o.start    = start_req_i;
    entry_o.finish   = finish_i;
    entry_o.has_byte = has_byte_i;
    entry_o.data     = data_byte_i;
    entry_o.addr     = register_address_i;
    entry_o.len      = payload_length_i + 8'd2;
    if (frame_kind_i) begin
      entry_o.hdr = cfg_i.job_type_bits | cfg_i.broadcast_group_bits;
    end else begin
      entry_o.hdr = cfg_i.command_type_bits | group_code_i | command_code_i;
    end
  end

endmodule

// ===== rtl/core/cjfb_queue.sv =====
module cjfb_queue
  import cjfb_pkg::*;
#(
  parameter int unsigned DEPTH = CJFB_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  job_entry_t entry_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       empty_o,
  output job_entry_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  job_entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o) else $error("queue pushed while full");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH)) else $error("queue count beyond depth");

endmodule

// ===== rtl/core/cjfb_back.sv =====
module cjfb_back
  import cjfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       head_valid_i,
  input  job_entry_t head_i,
  output logic       pop_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o,
  output logic       run_end_o
);

  slot_e       slot_q, slot_d, cur_slot, next_slot, crc_first, after_addr;
  logic        mid_q, mid_d;
  logic        kind_q;
  logic [4:0]  crc5_q;
  logic [15:0] crc16_q;
  logic        fire;
  logic [7:0]  out_byte;
  logic        out_fend;
  logic        ov_q;
  logic [7:0]  byte_q;
  logic        fend_q, rend_q;

  assign fire = head_valid_i & (~ov_q | m_ready_i);

  always_comb begin
    crc_first  = kind_q ? SL_CRC_HI : SL_CRC5;
    after_addr = head_i.has_byte ? SL_DATA : (head_i.finish ? crc_first : SL_DONE);

    if (mid_q) begin
      cur_slot = slot_q;
    end else if (head_i.start) begin
      cur_slot = SL_PRE1;
    end else if (head_i.has_byte) begin
      cur_slot = SL_DATA;
    end else begin
      cur_slot = crc_first;
    end

    // kind_q already holds the new frame's kind once the first preamble is out
    case (cur_slot)
      SL_PRE1:   next_slot = SL_PRE2;
      SL_PRE2:   next_slot = SL_HDR;
      SL_HDR:    next_slot = SL_LEN;
      SL_LEN:    next_slot = kind_q ? after_addr : SL_ADDR;
      SL_ADDR:   next_slot = after_addr;
      SL_DATA:   next_slot = head_i.finish ? crc_first : SL_DONE;
      SL_CRC_HI: next_slot = SL_CRC_LO;
      default:   next_slot = SL_DONE;
    endcase

    case (cur_slot)
      SL_PRE1:   out_byte = cfg_i.preamble_first;
      SL_PRE2:   out_byte = cfg_i.preamble_second;
      SL_HDR:    out_byte = head_i.hdr;
      SL_LEN:    out_byte = head_i.len;
      SL_ADDR:   out_byte = head_i.addr;
      SL_DATA:   out_byte = head_i.data;
      SL_CRC_HI: out_byte = crc16_q[15:8];
      SL_CRC_LO: out_byte = crc16_q[7:0];
      SL_CRC5:   out_byte = {3'b000, crc5_q};
      default:   out_byte = 8'h00;
    endcase

    out_fend = (cur_slot == SL_CRC_LO) || (cur_slot == SL_CRC5);
    pop_o    = fire && (next_slot == SL_DONE);

    slot_d = slot_q;
    mid_d  = mid_q;
    if (fire) begin
      if (next_slot == SL_DONE) begin
        mid_d = 1'b0;
      end else begin
        mid_d  = 1'b1;
        slot_d = next_slot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= SL_PRE1;
      mid_q   <= 1'b0;
      kind_q  <= 1'b0;
      crc5_q  <= CRC5_SEED;
      crc16_q <= CRC16_SEED;
      ov_q    <= 1'b0;
    end else begin
      slot_q <= slot_d;
      mid_q  <= mid_d;
      if (fire) begin
        ov_q <= 1'b1;
      end else if (m_ready_i) begin
        ov_q <= 1'b0;
      end
      if (fire) begin
        case (cur_slot)
          SL_PRE1: begin
            kind_q  <= head_i.kind;
            crc5_q  <= CRC5_SEED;
            crc16_q <= CRC16_SEED;
          end
          SL_HDR, SL_LEN, SL_ADDR, SL_DATA: begin
            if (kind_q) crc16_q <= crc16_byte(crc16_q, out_byte);
            else        crc5_q  <= crc5_byte(crc5_q, out_byte);
          end
          SL_CRC_LO, SL_CRC5: begin
            crc5_q  <= CRC5_SEED;
            crc16_q <= CRC16_SEED;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= out_byte;
      fend_q <= out_fend;
      rend_q <= (next_slot == SL_DONE);
    end
  end

  assign m_valid_o    = ov_q;
  assign frame_byte_o = byte_q;
  assign frame_end_o  = fend_q;
  assign run_end_o    = rend_q;

  a_fend_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && fend_q |-> rend_q) else $error("frame end beat is not last of its run");
  a_mid_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_q |-> head_valid_i) else $error("sequencer mid entry with empty queue");
  a_crc_hi_then_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && cur_slot == SL_CRC_HI |=> mid_q && slot_q == SL_CRC_LO)
    else $error("crc16 high byte not followed by low byte");

endmodule

// ===== rtl/core/command_and_job_frame_builder.sv =====
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid_i/tready_o       tdata 40b, tuser 3b, tlast (finish)
// m_axis    out  m_axis_tvalid_o/tready_i       tdata 8b, tuser 1b, tlast (frame_end)
// apb       in   psel/penable/pwrite, pready=1  five 8-bit registers at 4*i
//
// one input beat per cycle is taken while the queue has room; the queue
// depth (QUEUE_DEPTH) decouples input from output
// each beat expands into 1 to 7 output bytes, sent one per cycle by the
// byte sequencer; a mid-frame data beat sustains one byte per cycle
// the crc is updated a whole byte per cycle in the sequencer
// reset clears queue, sequencer and crc state and loads register defaults
// a stalled output holds the sequencer; the queue keeps taking input
module command_and_job_frame_builder
  import cjfb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = CJFB_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // data_byte, command_code, group_code, register_address, payload_length
  input  logic [39:0] s_axis_tdata_i,
  // frame_kind, start_req, has_byte
  input  logic [2:0]  s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // frame_byte
  output logic [7:0]  m_axis_tdata_o,
  // run_end
  output logic [0:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_q;
  logic       full, empty, push, pop;
  job_entry_t entry, head;
  logic [2:0] reg_idx;
  logic       run_end;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preamble_first       <= 8'h55;
      cfg_q.preamble_second      <= 8'hAA;
      cfg_q.command_type_bits    <= 8'h40;
      cfg_q.job_type_bits        <= 8'h20;
      cfg_q.broadcast_group_bits <= 8'h10;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_PREAMBLE_FIRST:  cfg_q.preamble_first       <= pwdata[7:0];
        REG_PREAMBLE_SECOND: cfg_q.preamble_second      <= pwdata[7:0];
        REG_COMMAND_TYPE:    cfg_q.command_type_bits    <= pwdata[7:0];
        REG_JOB_TYPE:        cfg_q.job_type_bits        <= pwdata[7:0];
        REG_BROADCAST_GROUP: cfg_q.broadcast_group_bits <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PREAMBLE_FIRST:  prdata = {24'h0, cfg_q.preamble_first};
      REG_PREAMBLE_SECOND: prdata = {24'h0, cfg_q.preamble_second};
      REG_COMMAND_TYPE:    prdata = {24'h0, cfg_q.command_type_bits};
      REG_JOB_TYPE:        prdata = {24'h0, cfg_q.job_type_bits};
      REG_BROADCAST_GROUP: prdata = {24'h0, cfg_q.broadcast_group_bits};
      default:             prdata = 32'h0;
    endcase
  end

  cjfb_front u_front (
    .s_valid_i          (s_axis_tvalid_i),
    .s_ready_o          (s_axis_tready_o),
    .frame_kind_i       (s_axis_tuser_i[0]),
    .start_req_i        (s_axis_tuser_i[1]),
    .finish_i           (s_axis_tlast_i),
    .has_byte_i         (s_axis_tuser_i[2]),
    .data_byte_i        (s_axis_tdata_i[7:0]),
    .command_code_i     (s_axis_tdata_i[15:8]),
    .group_code_i       (s_axis_tdata_i[23:16]),
    .register_address_i (s_axis_tdata_i[31:24]),
    .payload_length_i   (s_axis_tdata_i[39:32]),
    .cfg_i              (cfg_q),
    .full_i             (full),
    .push_o             (push),
    .entry_o            (entry)
  );

  cjfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  cjfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (~empty),
    .head_i       (head),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .frame_byte_o (m_axis_tdata_o),
    .frame_end_o  (m_axis_tlast_o),
    .run_end_o    (run_end)
  );

  assign m_axis_tuser_o = run_end;

endmodule
